// ===== rtl/sorted_list_pool_engine_macros.svh =====
// assertion helpers for the sorted list pool engine
`ifndef SORTED_LIST_POOL_ENGINE_MACROS_SVH
`define SORTED_LIST_POOL_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SLPE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SLPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/slpe_pkg.sv =====
package slpe_pkg;

    localparam int POOL_SLOTS = 32;
    localparam int VALUE_BITS = 32;

    localparam int SLOT_W  = $clog2(POOL_SLOTS);
    localparam int LINK_W  = $clog2(POOL_SLOTS + 1);
    localparam int COUNT_W = $clog2(POOL_SLOTS + 1);

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

// ===== rtl/sorted_list_pool_engine.sv =====
// Sorted list pool engine. Issue a command word by raising start while busy is low; the
// result word appears on o_status, o_slot and o_entry_count for one cycle with o_valid
// high and cannot be held off, so the receiver must take it in that cycle. Node values
// and links live in two synchronous memories, each with one write and one read port; a
// command walks the list one node per cycle through the read port. A command that answers
// at once (pool full, delete on an empty list) gives its word in the cycle after
// acceptance with busy staying low; an insert on an empty list passes through S_WRITE
// before its word appears. Otherwise a delete passes through S_READ and then S_CHECK
// for each node visited, and an insert does the same and then S_WRITE (and S_LINK
// when the new node is not the head, for the extra link write): a delete visits at most
// 32 nodes, and an insert at most 31, since a 32-node list leaves no free slot.
`include "sorted_list_pool_engine_macros.svh"

module sorted_list_pool_engine
    import slpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [31:0] i_value,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [4:0]  o_slot,
    output logic [5:0]  o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_LINK
    } t_state;

    // node memories
    logic [VALUE_BITS-1:0] r_mem_value [POOL_SLOTS];
    logic [LINK_W-1:0]     r_mem_link  [POOL_SLOTS];
    logic [VALUE_BITS-1:0] r_rd_value;
    logic [LINK_W-1:0]     r_rd_link;

    t_state                r_state, n_state;
    logic                  r_cmd, n_cmd;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [SLOT_W-1:0]     r_fresh, n_fresh;
    logic [LINK_W-1:0]     r_prev, n_prev;
    logic [LINK_W-1:0]     r_cur, n_cur;
    logic [COUNT_W-1:0]    r_steps, n_steps;
    logic [LINK_W-1:0]     r_head, n_head;
    logic [COUNT_W-1:0]    r_total, n_total;
    logic [POOL_SLOTS-1:0] r_in_use, n_in_use;
    logic                  r_valid, n_valid;
    t_status               r_status, n_status;
    logic [SLOT_W-1:0]     r_out_slot, n_out_slot;

    logic [VALUE_BITS-1:0] w_value;
    logic                  w_any_free;
    logic [SLOT_W-1:0]     w_free_slot;
    logic                  w_link_ok;
    logic [LINK_W-1:0]     w_next_cur;
    logic                  w_last;
    logic [LINK_W-1:0]     w_rd_addr;
    logic                  w_val_we;
    logic                  w_lk_we;
    logic [LINK_W-1:0]     w_lk_addr;
    logic [LINK_W-1:0]     w_lk_data;

    assign w_value = VALUE_BITS'(i_value);

    // lowest free slot
    always_comb begin
        w_any_free  = 1'b0;
        w_free_slot = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_any_free  = 1'b1;
                w_free_slot = SLOT_W'(i);
            end
        end
    end

    assign w_link_ok  = (r_rd_link < NULL_LINK);
    assign w_next_cur = w_link_ok ? r_rd_link : NULL_LINK;
    assign w_last     = (r_steps == COUNT_W'(POOL_SLOTS - 1));

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_fresh    = r_fresh;
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_steps    = r_steps;
        n_head     = r_head;
        n_total    = r_total;
        n_in_use   = r_in_use;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_out_slot = r_out_slot;
        w_rd_addr  = r_cur;
        w_val_we   = 1'b0;
        w_lk_we    = 1'b0;
        w_lk_addr  = r_prev;
        w_lk_data  = r_cur;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_command;
                    n_value = w_value;
                    n_fresh = w_free_slot;
                    n_prev  = NULL_LINK;
                    n_cur   = r_head;
                    n_steps = '0;
                    if (i_command == CMD_INSERT && !w_any_free) begin
                        n_valid    = 1'b1;
                        n_status   = ST_FULL;
                        n_out_slot = '0;
                    end else if (r_head >= NULL_LINK) begin
                        n_cur = NULL_LINK;
                        if (i_command == CMD_INSERT) begin
                            n_state = S_WRITE;
                        end else begin
                            n_valid    = 1'b1;
                            n_status   = ST_NOT_FOUND;
                            n_out_slot = '0;
                        end
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_cmd == CMD_INSERT && r_rd_value > r_value) begin
                    n_state = S_WRITE;
                end else if (r_cmd == CMD_DELETE && r_rd_value == r_value) begin
                    if (r_prev == NULL_LINK) begin
                        n_head = w_next_cur;
                    end else begin
                        w_lk_we   = 1'b1;
                        w_lk_addr = r_prev;
                        w_lk_data = w_next_cur;
                    end
                    n_in_use[r_cur[SLOT_W-1:0]] = 1'b0;
                    if (r_total != '0) begin
                        n_total = COUNT_W'(r_total - 1'b1);
                    end
                    n_valid    = 1'b1;
                    n_status   = ST_DELETED;
                    n_out_slot = r_cur[SLOT_W-1:0];
                    n_state    = S_IDLE;
                end else begin
                    // advance, reading the next node straight from the link
                    n_prev    = r_cur;
                    n_cur     = w_next_cur;
                    n_steps   = COUNT_W'(r_steps + 1'b1);
                    w_rd_addr = r_rd_link;
                    if (!w_link_ok || w_last) begin
                        if (r_cmd == CMD_INSERT) begin
                            n_state = S_WRITE;
                        end else begin
                            n_valid    = 1'b1;
                            n_status   = ST_NOT_FOUND;
                            n_out_slot = '0;
                            n_state    = S_IDLE;
                        end
                    end
                end
            end
            S_WRITE: begin
                w_val_we  = 1'b1;
                w_lk_we   = 1'b1;
                w_lk_addr = LINK_W'(r_fresh);
                w_lk_data = r_cur;
                if (r_prev == NULL_LINK) begin
                    n_head                = LINK_W'(r_fresh);
                    n_in_use[r_fresh]     = 1'b1;
                    n_total               = COUNT_W'(r_total + 1'b1);
                    n_valid               = 1'b1;
                    n_status              = ST_INSERTED;
                    n_out_slot            = r_fresh;
                    n_state               = S_IDLE;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                w_lk_we           = 1'b1;
                w_lk_addr         = r_prev;
                w_lk_data         = LINK_W'(r_fresh);
                n_in_use[r_fresh] = 1'b1;
                n_total           = COUNT_W'(r_total + 1'b1);
                n_valid           = 1'b1;
                n_status          = ST_INSERTED;
                n_out_slot        = r_fresh;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            r_mem_value[r_fresh] <= r_value;
        end
        r_rd_value <= r_mem_value[w_rd_addr[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_lk_we) begin
            r_mem_link[w_lk_addr[SLOT_W-1:0]] <= w_lk_data;
        end
        r_rd_link <= r_mem_link[w_rd_addr[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NULL_LINK;
            r_total  <= '0;
            r_in_use <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmd      <= n_cmd;
            r_value    <= n_value;
            r_fresh    <= n_fresh;
            r_prev     <= n_prev;
            r_cur      <= n_cur;
            r_steps    <= n_steps;
            r_head     <= n_head;
            r_total    <= n_total;
            r_in_use   <= n_in_use;
            r_valid    <= n_valid;
            r_status   <= n_status;
            r_out_slot <= n_out_slot;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_slot        = 5'(r_out_slot);
    assign o_entry_count = 6'(r_total);

    `SLPE_ASSERT_NOW(a_count_matches_use, i_clk, i_rst_n, 1'b1, r_total == COUNT_W'($countones(r_in_use)), "node count differs from slots in use")
    `SLPE_ASSERT_NOW(a_head_matches_count, i_clk, i_rst_n, 1'b1, (r_total == '0) == (r_head == NULL_LINK), "list head disagrees with node count")
    `SLPE_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, o_valid || busy, "accepted word neither answered nor in progress")
    `SLPE_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, o_valid, !busy, "result word while still busy")

endmodule
